/* hdl/tepc_pkg.sv */
// ----------------------------------------------------------------------------
// tepc_pkg: shared types and constants of the timed entry pool compactor
// Field widths, stream packing sizes, item kinds and the command and result
// records passed between the front end, the command queue and the engine.
// ----------------------------------------------------------------------------
package tepc_pkg;

    // Field widths
    localparam int KIND_W    = 2;
    localparam int ELAPSED_W = 31;
    localparam int VAL_W     = 32;
    localparam int IDX_W     = 6;
    localparam int LIVE_W    = 7;

    // Stream packing
    localparam int S_TDATA_W = 264;
    localparam int S_TUSER_W = KIND_W;
    localparam int M_TDATA_W = 232;
    localparam int M_TUSER_W = 2;

    // Defaults and sizes
    localparam int POOL_DEPTH_DEF = 64;
    localparam int QUEUE_DEPTH    = 2;

    // Item kinds as they arrive on tuser
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_INSERT,
        OP_READ,
        OP_NOP
    } op_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] life;
        logic signed [VAL_W-1:0] start_x;
        logic signed [VAL_W-1:0] start_y;
        logic signed [VAL_W-1:0] start_z;
        logic signed [VAL_W-1:0] end_x;
        logic signed [VAL_W-1:0] end_y;
        logic signed [VAL_W-1:0] end_z;
    } entry_t;

    typedef struct packed {
        op_t                  op;
        logic [ELAPSED_W-1:0] elapsed;
        entry_t               entry;
        logic [IDX_W-1:0]     read_index;
    } cmd_t;

    typedef struct packed {
        logic [LIVE_W-1:0] live_count;
        logic              accepted;
        logic              read_valid;
        entry_t            entry;
    } res_t;

endpackage

/* hdl/tepc_front.sv */
// ----------------------------------------------------------------------------
// tepc_front: input beat capture and classification
// Takes input beats, decodes the kind into an operation and holds the
// command in one register until the command queue takes it.
// ----------------------------------------------------------------------------
module tepc_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tepc_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [tepc_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            q_valid,
    input  logic                            q_ready,
    output tepc_pkg::cmd_t                  q_cmd
);
    import tepc_pkg::*;

    logic valid_reg, valid_next;
    cmd_t cmd_reg, cmd_next;
    cmd_t dec;

    always_comb begin
        dec                  = '0;
        dec.elapsed          = s_tdata[30:0];
        dec.entry.life       = s_tdata[62:31];
        dec.entry.start_x    = s_tdata[94:63];
        dec.entry.start_y    = s_tdata[126:95];
        dec.entry.start_z    = s_tdata[158:127];
        dec.entry.end_x      = s_tdata[190:159];
        dec.entry.end_y      = s_tdata[222:191];
        dec.entry.end_z      = s_tdata[254:223];
        dec.read_index       = s_tdata[260:255];
        case (s_tuser)
            KIND_TICK:   dec.op = OP_TICK;
            KIND_INSERT: dec.op = OP_INSERT;
            KIND_READ:   dec.op = OP_READ;
            default:     dec.op = OP_NOP;
        endcase
    end

    assign s_tready = !valid_reg || q_ready;
    assign q_valid  = valid_reg;
    assign q_cmd    = cmd_reg;

    always_comb begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
            cmd_next   = dec;
        end else if (q_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        cmd_reg <= cmd_next;
    end

endmodule

/* hdl/tepc_cmd_queue.sv */
// ----------------------------------------------------------------------------
// tepc_cmd_queue: short command queue
// Decouples the front end from the engine so either side can stall alone.
// ----------------------------------------------------------------------------
module tepc_cmd_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  tepc_pkg::cmd_t  push_cmd,
    output logic            pop_valid,
    input  logic            pop_ready,
    output tepc_pkg::cmd_t  pop_cmd
);
    import tepc_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = count_reg < QCW'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QAW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QAW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + QCW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Occupancy never runs past the queue size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCW'(QUEUE_DEPTH))
        else $error("command queue occupancy overflow");

endmodule

/* hdl/tepc_engine.sv */
// ----------------------------------------------------------------------------
// tepc_engine: pool storage and command execution
// Holds the entry memory and live count, runs inserts, reads and the tick
// walk (decrement plus two-pointer compaction), and owns the result register.
// ----------------------------------------------------------------------------
module tepc_engine #(
    parameter int POOL_DEPTH = tepc_pkg::POOL_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  tepc_pkg::cmd_t  cmd,
    output logic            m_valid,
    input  logic            m_ready,
    output tepc_pkg::res_t  res
);
    import tepc_pkg::*;

    localparam int AW    = $clog2(POOL_DEPTH);
    localparam int CNT_W = $clog2(POOL_DEPTH + 1);
    localparam int CMP_W = CNT_W + IDX_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_EVAL,
        ST_RESULT
    } state_t;

    function automatic logic signed [VAL_W-1:0] sat_sub(
        input logic signed [VAL_W-1:0] a,
        input logic [ELAPSED_W-1:0]    b
    );
        logic signed [VAL_W:0] d;
        d = {a[VAL_W-1], a} - (VAL_W+1)'(b);
        if (d[VAL_W] != d[VAL_W-1]) begin
            sat_sub = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            sat_sub = d[VAL_W-1:0];
        end
    endfunction

    function automatic logic expired(input logic signed [VAL_W-1:0] life);
        expired = life[VAL_W-1] || (life == '0);
    endfunction

    // Entry memory: one write port, two registered read ports
    entry_t         pool_mem [POOL_DEPTH];
    entry_t         rd_a_reg, rd_b_reg;
    logic           mem_we, rd_a_en, rd_b_en;
    logic [AW-1:0]  mem_waddr, rd_a_addr, rd_b_addr;
    entry_t         mem_wdata;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     live_reg, live_next;
    logic [CNT_W-1:0]     lo_reg, lo_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic                 acc_reg, acc_next;
    logic                 rv_reg, rv_next;
    logic                 m_valid_reg, m_valid_next;
    res_t                 res_reg, res_next;

    logic [CNT_W-1:0]        n_minus1;
    logic signed [VAL_W-1:0] dec_lo, dec_hi;

    assign n_minus1  = n_reg - CNT_W'(1);
    assign dec_lo    = sat_sub(rd_a_reg.life, elapsed_reg);
    assign dec_hi    = sat_sub(rd_b_reg.life, elapsed_reg);
    assign cmd_ready = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign res       = res_reg;

    always_comb begin
        state_next   = state_reg;
        live_next    = live_reg;
        lo_next      = lo_reg;
        n_next       = n_reg;
        elapsed_next = elapsed_reg;
        acc_next     = acc_reg;
        rv_next      = rv_reg;
        m_valid_next = m_valid_reg;
        res_next     = res_reg;
        mem_we       = 1'b0;
        mem_waddr    = lo_reg[AW-1:0];
        mem_wdata    = rd_a_reg;
        rd_a_en      = 1'b0;
        rd_a_addr    = lo_reg[AW-1:0];
        rd_b_en      = 1'b0;
        rd_b_addr    = n_minus1[AW-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    acc_next = 1'b0;
                    rv_next  = 1'b0;
                    case (cmd.op)
                        OP_TICK: begin
                            elapsed_next = cmd.elapsed;
                            lo_next      = '0;
                            n_next       = live_reg;
                            state_next   = ST_PROBE;
                        end
                        OP_INSERT: begin
                            if (live_reg < CNT_W'(POOL_DEPTH)) begin
                                mem_we    = 1'b1;
                                mem_waddr = live_reg[AW-1:0];
                                mem_wdata = cmd.entry;
                                live_next = live_reg + CNT_W'(1);
                                acc_next  = 1'b1;
                            end
                            state_next = ST_RESULT;
                        end
                        OP_READ: begin
                            if (CMP_W'(cmd.read_index) < CMP_W'(live_reg)) begin
                                rd_a_en   = 1'b1;
                                rd_a_addr = AW'(cmd.read_index);
                                rv_next   = 1'b1;
                            end
                            state_next = ST_RESULT;
                        end
                        default: begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_PROBE: begin
                // slots in [lo, n) still hold undecremented lifetimes
                if (lo_reg < n_reg) begin
                    rd_a_en    = 1'b1;
                    rd_b_en    = 1'b1;
                    state_next = ST_EVAL;
                end else begin
                    live_next  = n_reg;
                    state_next = ST_RESULT;
                end
            end
            ST_EVAL: begin
                if (expired(dec_hi)) begin
                    n_next = n_minus1;
                end else if (!expired(dec_lo)) begin
                    mem_we         = 1'b1;
                    mem_wdata      = rd_a_reg;
                    mem_wdata.life = dec_lo;
                    lo_next        = lo_reg + CNT_W'(1);
                end else begin
                    // expired slot at the front takes the last live entry;
                    // the old front entry drops off the back unwritten
                    mem_we         = 1'b1;
                    mem_wdata      = rd_b_reg;
                    mem_wdata.life = dec_hi;
                    lo_next        = lo_reg + CNT_W'(1);
                    n_next         = n_minus1;
                end
                state_next = ST_PROBE;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    res_next.live_count = LIVE_W'(live_reg);
                    res_next.accepted   = acc_reg;
                    res_next.read_valid = rv_reg;
                    res_next.entry      = rv_reg ? rd_a_reg : '0;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            live_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            live_reg    <= live_next;
            m_valid_reg <= m_valid_next;
        end
        lo_reg      <= lo_next;
        n_reg       <= n_next;
        elapsed_reg <= elapsed_next;
        acc_reg     <= acc_next;
        rv_reg      <= rv_next;
        res_reg     <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pool_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_a_en) begin
            rd_a_reg <= pool_mem[rd_a_addr];
        end
        if (rd_b_en) begin
            rd_b_reg <= pool_mem[rd_b_addr];
        end
    end

    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= CNT_W'(POOL_DEPTH))
        else $error("live count above pool depth");

    a_eval_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL) |-> (lo_reg < n_reg))
        else $error("compaction evaluated an empty window");

    a_walk_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROBE || state_reg == ST_EVAL) |-> (n_reg <= live_reg))
        else $error("compaction count grew past live count");

endmodule

/* hdl/timed_entry_pool_compactor_core.sv */
// ----------------------------------------------------------------------------
// timed_entry_pool_compactor_core: timed entry pool with compaction
// Fixed pool of lifetime/segment entries with insert, read and tick items.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on s_t*; s_tuser carries the kind (tick, insert, read,
//   anything else is a no-op). Every accepted beat yields exactly one result
//   beat on m_t*, in order, carrying the live count, the insert-accepted and
//   read-valid flags (m_tuser) and the read entry (zero unless read_valid).
//   Insert, read and no-op beats pass through the capture register, the
//   command queue and the engine into the output register. A tick walks
//   the live slots in steps, each with two memory reads and at most one
//   write-back. That walk over the dual-read entry memory sets the
//   throughput; items run one at a time in the engine.
//   A capture register and a two-deep command queue keep s_tready high while
//   the engine works or while a result waits on m_tready, so up to three
//   beats can be taken ahead. A stalled result holds in the output register.
//   Reset (aresetn low, synchronous) empties the pool and clears all valids;
//   entry memory contents are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module timed_entry_pool_compactor_core #(
    parameter int POOL_DEPTH = tepc_pkg::POOL_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // elapsed, lifetime, start_x, start_y, start_z, end_x, end_y, end_z,
    // read_index, zero pad
    input  logic [tepc_pkg::S_TDATA_W-1:0]  s_tdata,
    // kind
    input  logic [tepc_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // live_count, out_lifetime, out_start_x, out_start_y, out_start_z,
    // out_end_x, out_end_y, out_end_z, zero pad
    output logic [tepc_pkg::M_TDATA_W-1:0]  m_tdata,
    // accepted, read_valid
    output logic [tepc_pkg::M_TUSER_W-1:0]  m_tuser
);
    import tepc_pkg::*;

    logic f_valid, f_ready;
    cmd_t f_cmd;
    logic q_valid, q_ready;
    cmd_t q_cmd;
    res_t res;

    // Capture and classify input beats
    tepc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (f_valid),
        .q_ready  (f_ready),
        .q_cmd    (f_cmd)
    );

    // Slack between front and engine
    tepc_cmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_cmd   (f_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    // Pool memory, tick walk and result register
    tepc_engine #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .res       (res)
    );

    // Result packing, lowest field first
    assign m_tdata[6:0]     = res.live_count;
    assign m_tdata[38:7]    = res.entry.life;
    assign m_tdata[70:39]   = res.entry.start_x;
    assign m_tdata[102:71]  = res.entry.start_y;
    assign m_tdata[134:103] = res.entry.start_z;
    assign m_tdata[166:135] = res.entry.end_x;
    assign m_tdata[198:167] = res.entry.end_y;
    assign m_tdata[230:199] = res.entry.end_z;
    assign m_tdata[231]     = 1'b0;
    assign m_tuser[0]       = res.accepted;
    assign m_tuser[1]       = res.read_valid;

endmodule
